// File: rtl/clsr_pkg.sv
`timescale 1ns / 1ps

package clsr_pkg;

    // Width of every generator value, table entry and result.
    localparam int unsigned VALUE_W = 31;

    // Combined generator moduli and Schrage constants.
    localparam logic [VALUE_W-1:0] IM1  = 31'd2147483563;
    localparam logic [VALUE_W-1:0] IM2  = 31'd2147483399;
    localparam logic [VALUE_W-1:0] IMM1 = 31'd2147483562;
    localparam logic [15:0]        IA1  = 16'd40014;
    localparam logic [15:0]        IA2  = 16'd40692;
    localparam logic [15:0]        IQ1  = 16'd53668;
    localparam logic [15:0]        IQ2  = 16'd52774;
    localparam logic [13:0]        IR1  = 14'd12211;
    localparam logic [13:0]        IR2  = 14'd3791;

    // Reset value of the second generator.
    localparam logic [VALUE_W-1:0] SEED_TWO_RESET = 31'd123456789;

    // Exact z / q by reciprocal multiply for any 31-bit z and 16-bit q:
    // shift = 31 + ceil(log2 q), reciprocal = ceil(2^shift / q).
    localparam int unsigned DIV_SHIFT = 47;
    localparam int unsigned HI_W      = 16;
    localparam logic [63:0] IQ1_RECIP_W =
        ((64'd1 << DIV_SHIFT) + 64'(IQ1) - 64'd1) / 64'(IQ1);
    localparam logic [63:0] IQ2_RECIP_W =
        ((64'd1 << DIV_SHIFT) + 64'(IQ2) - 64'd1) / 64'(IQ2);
    localparam logic [31:0] IQ1_RECIP = IQ1_RECIP_W[31:0];
    localparam logic [31:0] IQ2_RECIP = IQ2_RECIP_W[31:0];

    // Which generator a step belongs to.
    typedef enum logic {
        GEN_ONE,
        GEN_TWO
    } gen_t;

    // One request to, or one result from, the Schrage step pipeline.
    typedef struct packed {
        logic               valid;
        gen_t               gen;
        logic [VALUE_W-1:0] z;
    } step_t;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED_RUN,
        ST_DRAW_A,
        ST_DRAW_B,
        ST_DRAW_WAIT,
        ST_EMIT
    } state_t;

endpackage

// File: rtl/clsr_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module clsr_ram #(
    parameter int unsigned WIDTH = 31,
    parameter int unsigned DEPTH = 32,
    localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/clsr_schrage.sv
`timescale 1ns / 1ps

// Four-stage pipeline for one Schrage step z <- a*(z - hi*q) - hi*r (+m),
// with hi = z / q. The constants follow the generator tag of each item,
// so both generators share the pipeline and may be issued back to back.
module clsr_schrage (
    input  logic            clk,
    input  logic            rst_n,
    input  clsr_pkg::step_t step_in,
    output clsr_pkg::step_t step_out
);

    // Stage valid bits and tags.
    logic [3:0]           valid_reg;
    logic [3:0]           valid_next;
    clsr_pkg::gen_t       gen1_reg, gen2_reg, gen3_reg, gen4_reg;

    // Stage payloads.
    logic [30:0]          z1_reg;
    logic [62:0]          prod1_reg, prod1_next;
    logic [15:0]          hi2_reg, hi2_next;
    logic [15:0]          lo2_reg, lo2_next;
    logic [31:0]          pa3_reg, pa3_next;
    logic [29:0]          pb3_reg, pb3_next;
    logic [30:0]          nz4_reg, nz4_next;

    // Constants per stage.
    logic [31:0]          recip1;
    logic [15:0]          q2;
    logic [15:0]          a3;
    logic [13:0]          r3;
    logic [30:0]          m4;

    logic [15:0]          hi_calc;
    logic [31:0]          lo_full;
    logic [32:0]          diff;
    logic [32:0]          diff_wrap;

    // Constant selection by generator tag.
    always_comb
    begin
        recip1 = (step_in.gen == clsr_pkg::GEN_ONE) ? clsr_pkg::IQ1_RECIP
                                                    : clsr_pkg::IQ2_RECIP;
        q2     = (gen1_reg == clsr_pkg::GEN_ONE) ? clsr_pkg::IQ1 : clsr_pkg::IQ2;
        a3     = (gen2_reg == clsr_pkg::GEN_ONE) ? clsr_pkg::IA1 : clsr_pkg::IA2;
        r3     = (gen2_reg == clsr_pkg::GEN_ONE) ? clsr_pkg::IR1 : clsr_pkg::IR2;
        m4     = (gen3_reg == clsr_pkg::GEN_ONE) ? clsr_pkg::IM1 : clsr_pkg::IM2;
    end

    // Stage arithmetic: quotient estimate, remainder, products, final sum.
    always_comb
    begin
        prod1_next = 63'(step_in.z) * 63'(recip1);

        hi_calc    = prod1_reg[clsr_pkg::DIV_SHIFT +: clsr_pkg::HI_W];
        lo_full    = 32'(z1_reg) - 32'(hi_calc) * 32'(q2);
        hi2_next   = hi_calc;
        lo2_next   = lo_full[15:0];

        pa3_next   = 32'(lo2_reg) * 32'(a3);
        pb3_next   = 30'(hi2_reg) * 30'(r3);

        diff       = 33'(pa3_reg) - 33'(pb3_reg);
        diff_wrap  = diff + 33'(m4);
        nz4_next   = diff[32] ? diff_wrap[30:0] : diff[30:0];

        valid_next = {valid_reg[2:0], step_in.valid};
    end

    // Valid bits clear on reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        gen1_reg  <= step_in.gen;
        z1_reg    <= step_in.z;
        prod1_reg <= prod1_next;
        gen2_reg  <= gen1_reg;
        hi2_reg   <= hi2_next;
        lo2_reg   <= lo2_next;
        gen3_reg  <= gen2_reg;
        pa3_reg   <= pa3_next;
        pb3_reg   <= pb3_next;
        gen4_reg  <= gen3_reg;
        nz4_reg   <= nz4_next;
    end

    assign step_out = '{valid: valid_reg[3], gen: gen4_reg, z: nz4_reg};

endmodule

// File: rtl/combined_lcg_shuffle_rng.sv
`timescale 1ns / 1ps

// Channel  Direction  Signals                    Contents
// s_*      in         tvalid tready tuser tdata  tuser: reseed; tdata: seed
// m_*      out        tvalid tready tdata        tdata: value
//
// A draw steps the first generator, then the second generator with the table
// read; the result is loaded when the second step leaves the pipeline. A reseed
// runs 40 dependent passes through the 4-stage Schrage pipeline, then a draw.
// Reset needs no clearing pass: per-entry valid bits make unwritten table
// entries read as zero. A result not yet taken holds the sequencer until the
// output register frees up; no new item is accepted while it waits.
module combined_lcg_shuffle_rng #(
    parameter int unsigned TABLE_ENTRIES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tuser,   // [0] reseed
    input  logic [31:0] s_tdata,   // [30:0] seed, [31] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [30:0] value, [31] zero
);

    localparam int unsigned VW        = clsr_pkg::VALUE_W;
    localparam int unsigned IDX_W     = $clog2(TABLE_ENTRIES);
    localparam int unsigned QW        = IDX_W + 1;
    localparam int unsigned CNT_W     = $clog2(TABLE_ENTRIES + 8);
    localparam logic [63:0] NDIV      = 64'd1 + 64'(clsr_pkg::IMM1) / 64'(TABLE_ENTRIES);
    localparam int unsigned NDIV_LOG  = $clog2(NDIV);
    localparam int unsigned IDX_SHIFT = VW + NDIV_LOG;
    localparam logic [63:0] IDX_RECIP_W = ((64'd1 << IDX_SHIFT) + NDIV - 64'd1) / NDIV;
    localparam logic [32:0] IDX_RECIP = IDX_RECIP_W[32:0];

    clsr_pkg::state_t          state_reg, state_next;
    logic [VW-1:0]             gen_one_reg, gen_one_next;
    logic [VW-1:0]             gen_two_reg, gen_two_next;
    logic [VW-1:0]             last_out_reg, last_out_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [TABLE_ENTRIES-1:0]  tbl_valid_reg, tbl_valid_next;
    logic                      out_valid_reg, out_valid_next;
    logic [VW-1:0]             out_value_reg, out_value_next;
    logic [63:0]               idx_prod_reg, idx_prod_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic                      rd_valid_reg, rd_valid_next;

    clsr_pkg::step_t           step_in, step_out;
    logic                      ram_wr_en;
    logic [IDX_W-1:0]          ram_wr_addr;
    logic [VW-1:0]             ram_wr_data;
    logic                      ram_rd_en;
    logic [VW-1:0]             ram_rd_data;

    logic                      accept;
    logic                      out_free;
    logic                      g1_arrive;
    logic                      g2_arrive;
    logic [VW-1:0]             seed_fixed;
    logic [QW-1:0]             idx_quot;
    logic [IDX_W-1:0]          idx_sel;
    logic [VW-1:0]             tab_value;
    logic [32:0]               diff;
    logic [32:0]               diff_wrap;
    logic [VW-1:0]             draw_value;

    // Shuffle table storage.
    clsr_ram #(
        .WIDTH (VW),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (idx_sel),
        .rd_data (ram_rd_data)
    );

    // Shared Schrage step pipeline for both generators.
    clsr_schrage u_step (
        .clk      (clk),
        .rst_n    (rst_n),
        .step_in  (step_in),
        .step_out (step_out)
    );

    // Handshake and shared datapath terms.
    assign s_tready  = (state_reg == clsr_pkg::ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign g1_arrive = step_out.valid && (step_out.gen == clsr_pkg::GEN_ONE);
    assign g2_arrive = step_out.valid && (step_out.gen == clsr_pkg::GEN_TWO);

    always_comb
    begin
        seed_fixed = (s_tdata[VW-1:0] == '0) ? VW'(1) : s_tdata[VW-1:0];

        // Table index is last output divided by NDIV, clamped to the top entry.
        idx_quot = idx_prod_reg[IDX_SHIFT +: QW];
        if (idx_quot > QW'(TABLE_ENTRIES - 1))
        begin
            idx_sel = IDX_W'(TABLE_ENTRIES - 1);
        end
        else
        begin
            idx_sel = idx_quot[IDX_W-1:0];
        end

        // Combined output: table entry minus second generator, wrapped into range.
        tab_value  = rd_valid_reg ? ram_rd_data : '0;
        diff       = 33'(tab_value) - 33'(step_out.z);
        diff_wrap  = diff + 33'(clsr_pkg::IMM1);
        draw_value = (diff[32] || (diff == '0)) ? diff_wrap[VW-1:0] : diff[VW-1:0];
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            clsr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = s_tuser ? clsr_pkg::ST_SEED_RUN : clsr_pkg::ST_DRAW_B;
                end
            end
            clsr_pkg::ST_SEED_RUN:
            begin
                if (g1_arrive && (cnt_reg == '0))
                begin
                    state_next = clsr_pkg::ST_DRAW_A;
                end
            end
            clsr_pkg::ST_DRAW_A:
            begin
                state_next = clsr_pkg::ST_DRAW_B;
            end
            clsr_pkg::ST_DRAW_B:
            begin
                state_next = clsr_pkg::ST_DRAW_WAIT;
            end
            clsr_pkg::ST_DRAW_WAIT:
            begin
                if (g2_arrive)
                begin
                    state_next = out_free ? clsr_pkg::ST_IDLE : clsr_pkg::ST_EMIT;
                end
            end
            clsr_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = clsr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = clsr_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath control: pipeline issue, table access and register updates.
    always_comb
    begin
        step_in        = '{valid: 1'b0, gen: clsr_pkg::GEN_ONE, z: gen_one_reg};
        gen_one_next   = gen_one_reg;
        gen_two_next   = gen_two_reg;
        last_out_next  = last_out_reg;
        cnt_next       = cnt_reg;
        tbl_valid_next = tbl_valid_reg;
        idx_prod_next  = idx_prod_reg;
        idx_next       = idx_reg;
        rd_valid_next  = rd_valid_reg;
        out_value_next = out_value_reg;
        out_valid_next = out_valid_reg && !m_tready;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = idx_reg;
        ram_wr_data    = gen_one_reg;
        ram_rd_en      = 1'b0;

        case (state_reg)
            clsr_pkg::ST_IDLE:
            begin
                if (accept && s_tuser)
                begin
                    // Reseed: both generators start from the seed.
                    step_in      = '{valid: 1'b1, gen: clsr_pkg::GEN_ONE, z: seed_fixed};
                    gen_two_next = seed_fixed;
                    cnt_next     = CNT_W'(TABLE_ENTRIES + 7);
                end
                else if (accept)
                begin
                    // Draw: step the first generator and start the index divide.
                    step_in       = '{valid: 1'b1, gen: clsr_pkg::GEN_ONE, z: gen_one_reg};
                    idx_prod_next = 64'(last_out_reg) * 64'(IDX_RECIP);
                end
            end
            clsr_pkg::ST_SEED_RUN:
            begin
                // Warm-up steps; the last TABLE_ENTRIES of them load the table.
                if (g1_arrive)
                begin
                    gen_one_next = step_out.z;
                    if (cnt_reg < CNT_W'(TABLE_ENTRIES))
                    begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = cnt_reg[IDX_W-1:0];
                        ram_wr_data = step_out.z;
                        tbl_valid_next[cnt_reg[IDX_W-1:0]] = 1'b1;
                    end
                    if (cnt_reg == '0)
                    begin
                        last_out_next = step_out.z;
                    end
                    else
                    begin
                        step_in  = '{valid: 1'b1, gen: clsr_pkg::GEN_ONE, z: step_out.z};
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                end
            end
            clsr_pkg::ST_DRAW_A:
            begin
                step_in       = '{valid: 1'b1, gen: clsr_pkg::GEN_ONE, z: gen_one_reg};
                idx_prod_next = 64'(last_out_reg) * 64'(IDX_RECIP);
            end
            clsr_pkg::ST_DRAW_B:
            begin
                // Step the second generator and read the selected table entry.
                step_in       = '{valid: 1'b1, gen: clsr_pkg::GEN_TWO, z: gen_two_reg};
                ram_rd_en     = 1'b1;
                idx_next      = idx_sel;
                rd_valid_next = tbl_valid_reg[idx_sel];
            end
            clsr_pkg::ST_DRAW_WAIT:
            begin
                if (g1_arrive)
                begin
                    gen_one_next = step_out.z;
                end
                if (g2_arrive)
                begin
                    // Refill the used entry from the first generator and emit.
                    gen_two_next   = step_out.z;
                    last_out_next  = draw_value;
                    ram_wr_en      = 1'b1;
                    ram_wr_addr    = idx_reg;
                    ram_wr_data    = gen_one_reg;
                    tbl_valid_next[idx_reg] = 1'b1;
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_value_next = draw_value;
                    end
                end
            end
            clsr_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = last_out_reg;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && !m_tready;
            end
        endcase
    end

    // Control and generator state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= clsr_pkg::ST_IDLE;
            gen_one_reg   <= VW'(1);
            gen_two_reg   <= clsr_pkg::SEED_TWO_RESET;
            last_out_reg  <= '0;
            cnt_reg       <= '0;
            tbl_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gen_one_reg   <= gen_one_next;
            gen_two_reg   <= gen_two_next;
            last_out_reg  <= last_out_next;
            cnt_reg       <= cnt_next;
            tbl_valid_reg <= tbl_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        idx_prod_reg  <= idx_prod_next;
        idx_reg       <= idx_next;
        rd_valid_reg  <= rd_valid_next;
        out_value_reg <= out_value_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_value_reg};

endmodule

// File: rtl/clsr_checker.sv
`timescale 1ns / 1ps

// Port-level checks on the generator.
module clsr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // A result always lies in 1..IMM1 with the pad bit clear.
    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[30:0] != '0) && (m_tdata[30:0] <= clsr_pkg::IMM1)
                     && !m_tdata[31])
        else $error("result outside 1..IMM1");

    // Items are handled one at a time: the input closes after an acceptance.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item is in work");

    // A new result only appears while an item is in work.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared with no item in work");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind combined_lcg_shuffle_rng clsr_checker u_checker (.*);
